[rtl/rtp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rtp_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_SSRC = 2'd0;
  localparam logic [1:0] CFG_PT   = 2'd1;
  localparam logic [1:0] CFG_MAX  = 2'd2;

  localparam logic [31:0] SSRC_RESET = 32'h1234_5678;
  localparam logic [6:0]  PT_RESET   = 7'd96;
  localparam logic [13:0] MAX_RESET  = 14'd1400;
  localparam logic [13:0] MAX_FLOOR  = 14'd16;

  localparam int LEN_BITS_DEF = 24;
  localparam int QDEPTH_DEF   = 4;

  localparam logic [7:0] RTP_VER_BYTE = 8'h80;
  localparam logic [7:0] FU_A_TYPE    = 8'd28;
  localparam logic [7:0] NRI_MASK     = 8'h60;

  // Byte positions within one packet command
  localparam logic [3:0] POS_VER     = 4'd0;
  localparam logic [3:0] POS_PT      = 4'd1;
  localparam logic [3:0] POS_SEQ_HI  = 4'd2;
  localparam logic [3:0] POS_SEQ_LO  = 4'd3;
  localparam logic [3:0] POS_TS3     = 4'd4;
  localparam logic [3:0] POS_TS2     = 4'd5;
  localparam logic [3:0] POS_TS1     = 4'd6;
  localparam logic [3:0] POS_TS0     = 4'd7;
  localparam logic [3:0] POS_SSRC3   = 4'd8;
  localparam logic [3:0] POS_SSRC2   = 4'd9;
  localparam logic [3:0] POS_SSRC1   = 4'd10;
  localparam logic [3:0] POS_SSRC0   = 4'd11;
  localparam logic [3:0] POS_FU_IND  = 4'd12;
  localparam logic [3:0] POS_FU_HDR  = 4'd13;
  localparam logic [3:0] POS_DATA    = 4'd14;

  // One classified NAL byte: optional RTP header, optional FU bytes, then data
  typedef struct packed {
    logic        hdr;
    logic        fu;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        last;
  } rtp_cmd_t;

endpackage

`default_nettype wire

[rtl/rtp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtp_front
  import rtp_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  nal_byte,
  input  wire logic        nal_first,
  input  wire logic [23:0] nal_length,
  input  wire logic        au_end,
  input  wire logic [31:0] stamp,
  input  wire logic [13:0] max_payload,
  output rtp_cmd_t         cmd,
  output logic             cmd_valid
);

  localparam int CW = (LEN_BITS > 14) ? LEN_BITS : 14;

  logic [15:0]         seq_counter, seq_counter_next;
  logic                fragment_mode, fragment_mode_next;
  logic [LEN_BITS-1:0] bytes_left, bytes_left_next;
  logic [13:0]         fill_count, fill_count_next;
  logic [7:0]          saved_header, saved_header_next;
  logic                first_fragment, first_fragment_next;
  logic [31:0]         saved_stamp, saved_stamp_next;
  logic                saved_marker, saved_marker_next;

  logic [LEN_BITS-1:0] len_in, len, bl_dec;
  logic [13:0]         eff_max, room, fill_new;
  logic                endf, fits;

  always_comb begin
    len_in   = LEN_BITS'(nal_length);
    len      = (len_in == '0) ? LEN_BITS'(1) : len_in;
    eff_max  = (max_payload < MAX_FLOOR) ? MAX_FLOOR : max_payload;
    room     = eff_max - 14'd2;
    fits     = CW'(len) <= CW'(eff_max);
    bl_dec   = bytes_left - LEN_BITS'(1);
    endf     = CW'(bytes_left) <= CW'(room);
    fill_new = fill_count + 14'd1;

    seq_counter_next    = seq_counter;
    fragment_mode_next  = fragment_mode;
    bytes_left_next     = bytes_left;
    fill_count_next     = fill_count;
    saved_header_next   = saved_header;
    first_fragment_next = first_fragment;
    saved_stamp_next    = saved_stamp;
    saved_marker_next   = saved_marker;

    cmd_valid  = 1'b0;
    cmd.hdr    = 1'b0;
    cmd.fu     = 1'b0;
    cmd.marker = 1'b0;
    cmd.seq    = seq_counter;
    cmd.stamp  = saved_stamp;
    cmd.fu_ind = FU_A_TYPE | (saved_header & NRI_MASK);
    cmd.fu_hdr = {first_fragment, endf, 1'b0, saved_header[4:0]};
    cmd.data   = nal_byte;
    cmd.last   = 1'b0;

    if (nal_first) begin
      saved_header_next   = nal_byte;
      saved_stamp_next    = stamp;
      saved_marker_next   = au_end;
      fill_count_next     = '0;
      first_fragment_next = 1'b1;
      bytes_left_next     = len - LEN_BITS'(1);
      fragment_mode_next  = !fits;
      if (fits) begin
        cmd_valid        = 1'b1;
        cmd.hdr          = 1'b1;
        cmd.marker       = au_end;
        cmd.stamp        = stamp;
        cmd.last         = (len == LEN_BITS'(1));
        seq_counter_next = seq_counter + 16'd1;
      end
    end else if (bytes_left != '0) begin
      bytes_left_next = bl_dec;
      cmd_valid       = 1'b1;
      if (!fragment_mode) begin
        cmd.last = (bl_dec == '0);
      end else begin
        // Open a new fragment when nothing is in the current one yet
        if (fill_count == '0) begin
          cmd.hdr          = 1'b1;
          cmd.fu           = 1'b1;
          cmd.marker       = saved_marker & endf;
          seq_counter_next = seq_counter + 16'd1;
        end
        cmd.last        = (bl_dec == '0) || (fill_new >= room);
        fill_count_next = fill_new;
        if (cmd.last) begin
          fill_count_next     = '0;
          first_fragment_next = 1'b0;
        end
        if (bl_dec == '0) begin
          fragment_mode_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_counter    <= '0;
      fragment_mode  <= 1'b0;
      bytes_left     <= '0;
      fill_count     <= '0;
      first_fragment <= 1'b1;
      saved_header   <= '0;
      saved_stamp    <= '0;
      saved_marker   <= 1'b0;
    end else if (accept) begin
      seq_counter    <= seq_counter_next;
      fragment_mode  <= fragment_mode_next;
      bytes_left     <= bytes_left_next;
      fill_count     <= fill_count_next;
      first_fragment <= first_fragment_next;
      saved_header   <= saved_header_next;
      saved_stamp    <= saved_stamp_next;
      saved_marker   <= saved_marker_next;
    end
  end

endmodule

`default_nettype wire

[rtl/rtp_cmdq.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtp_cmdq
  import rtp_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  rtp_cmd_t  wr_cmd,
  input  wire logic rd,
  output rtp_cmd_t  rd_cmd,
  output logic      q_full,
  output logic      q_empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  rtp_cmd_t        slots [QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_wr, do_rd;

  assign q_full  = (count == CNTW'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNTW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/rtp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtp_back
  import rtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  rtp_cmd_t         head,
  input  wire logic        q_empty,
  output logic             q_rd,
  input  wire logic [31:0] ssrc_id,
  input  wire logic [6:0]  payload_kind,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       pkt_byte,
  output logic             pkt_last
);

  rtp_cmd_t   cur;
  logic       cur_valid;
  logic [3:0] pos;
  logic       take, fin, load;

  assign take  = cur_valid && pop;
  assign fin   = take && (pos == POS_DATA);
  assign load  = !q_empty && (!cur_valid || fin);
  assign q_rd  = load;
  assign empty = !cur_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= POS_VER;
    end else begin
      if (load) begin
        cur_valid <= 1'b1;
        pos       <= head.hdr ? POS_VER : POS_DATA;
      end else if (fin) begin
        cur_valid <= 1'b0;
      end else if (take) begin
        // skip the FU bytes for a whole NAL
        if (pos == POS_SSRC0) begin
          pos <= cur.fu ? POS_FU_IND : POS_DATA;
        end else begin
          pos <= pos + 4'd1;
        end
      end
    end
  end

  always_comb begin
    pkt_last = (pos == POS_DATA) && cur.last;
    unique case (pos)
      POS_VER:    pkt_byte = RTP_VER_BYTE;
      POS_PT:     pkt_byte = {cur.marker, payload_kind};
      POS_SEQ_HI: pkt_byte = cur.seq[15:8];
      POS_SEQ_LO: pkt_byte = cur.seq[7:0];
      POS_TS3:    pkt_byte = cur.stamp[31:24];
      POS_TS2:    pkt_byte = cur.stamp[23:16];
      POS_TS1:    pkt_byte = cur.stamp[15:8];
      POS_TS0:    pkt_byte = cur.stamp[7:0];
      POS_SSRC3:  pkt_byte = ssrc_id[31:24];
      POS_SSRC2:  pkt_byte = ssrc_id[23:16];
      POS_SSRC1:  pkt_byte = ssrc_id[15:8];
      POS_SSRC0:  pkt_byte = ssrc_id[7:0];
      POS_FU_IND: pkt_byte = cur.fu_ind;
      POS_FU_HDR: pkt_byte = cur.fu_hdr;
      POS_DATA:   pkt_byte = cur.data;
      default:    pkt_byte = cur.data;
    endcase
  end

endmodule

`default_nettype wire

[rtl/rtp_h264_nal_packetizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// RTP packetizer for H.264 NAL units (single NAL packets and FU-A fragments).
// Input channel: one NAL byte per beat (push/full). The first byte of a NAL
// carries nal_first, nal_length, au_end and stamp. Output channel: one RTP
// packet byte per beat (empty/pop), header first, pkt_last on the final byte.
// Configuration: write cfg_data to register cfg_index (0 SSRC, 1 payload type,
// 2 max payload) while cfg_we is high; write only while the block is idle.
// Structure: the front classifies each input beat and runs the NAL/fragment
// state and the sequence counter, pushing one command per beat that yields
// output into a 4-entry queue; the back expands a command into 1, 13 or 15
// output bytes (data, header + data, header + FU indicator/header + data).
// Flow: an accepted beat's command is written into the queue, then loaded
// into the back's current-command register, where its first byte shows.
// Rates: one input beat per cycle while full is low and one output beat per
// cycle while pop is high; each packet header adds 12 output bytes (14 for
// FU-A), absorbed by the queue and full, so the back's output sets the input rate.
// Reset: registers return to SSRC 0x12345678, payload type 96, max payload
// 1400; the sequence number restarts at 0 and the queue empties.
// Stall: while pop is low the current byte holds; the queue fills and full
// rises once it holds QDEPTH (4 by default) commands.
module rtp_h264_nal_packetizer
  import rtp_pkg::*;
#(
  parameter int LEN_BITS = LEN_BITS_DEF,
  parameter int QDEPTH   = QDEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  nal_byte,
  input  wire logic        nal_first,
  input  wire logic [23:0] nal_length,
  input  wire logic        au_end,
  input  wire logic [31:0] stamp,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       pkt_byte,
  output logic             pkt_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] ssrc_id;
  logic [6:0]  payload_kind;
  logic [13:0] max_payload;

  rtp_cmd_t front_cmd, head;
  logic     front_valid, accept, q_full, q_empty, q_rd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ssrc_id      <= SSRC_RESET;
      payload_kind <= PT_RESET;
      max_payload  <= MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SSRC: ssrc_id      <= cfg_data;
        CFG_PT:   payload_kind <= cfg_data[6:0];
        CFG_MAX:  max_payload  <= cfg_data[13:0];
        default:  ;
      endcase
    end
  end

  // Hold input whenever the queue cannot take another command
  assign full   = q_full;
  assign accept = push && !q_full;

  rtp_front #(
    .LEN_BITS(LEN_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .nal_byte    (nal_byte),
    .nal_first   (nal_first),
    .nal_length  (nal_length),
    .au_end      (au_end),
    .stamp       (stamp),
    .max_payload (max_payload),
    .cmd         (front_cmd),
    .cmd_valid   (front_valid)
  );

  rtp_cmdq #(
    .QDEPTH(QDEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept && front_valid),
    .wr_cmd  (front_cmd),
    .rd      (q_rd),
    .rd_cmd  (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  rtp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .ssrc_id      (ssrc_id),
    .payload_kind (payload_kind),
    .empty        (empty),
    .pop          (pop),
    .pkt_byte     (pkt_byte),
    .pkt_last     (pkt_last)
  );

endmodule

`default_nettype wire

[rtl/rtp_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtp_chk
  import rtp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] pkt_byte,
  input wire logic       pkt_last
);

  // High when the next output beat opens a packet
  logic at_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (pop && !empty) begin
      at_start <= pkt_last;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("output or queue not clear after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pkt_byte) && $stable(pkt_last)))
    else $error("waiting output beat changed");

  a_pkt_start: assert property (@(posedge clk) disable iff (rst)
    (!empty && at_start) |-> (pkt_byte == RTP_VER_BYTE && !pkt_last))
    else $error("packet does not open with an RTP version byte");

endmodule

bind rtp_h264_nal_packetizer rtp_chk u_rtp_chk (
  .clk      (clk),
  .rst      (rst),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .pkt_byte (pkt_byte),
  .pkt_last (pkt_last)
);

`default_nettype wire

[sim/tb_rtp_h264_nal_packetizer.sv]
`timescale 1ns / 1ps

module tb_rtp_h264_nal_packetizer;
  import rtp_pkg::*;

  localparam int          SETTLE_CYCLES = 16;       // extra idle wait once every owed beat is out
  localparam int          PHASE_BEATS   = 72;       // NAL beats per random phase, six phases
  localparam logic [4:0]  NO_CHECK      = 5'd31;    // table row leaves the count to the model
  localparam logic [1:0]  CFG_NONE      = 2'd3;     // index with no register behind it

  // One expected output beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_beat_t;

  typedef enum logic {ROW_NAL, ROW_REG} row_kind_t;

  typedef enum logic [1:0] {POP_ALWAYS, POP_RANDOM, POP_SPARSE, POP_BURSTY} pop_mode_t;

  // One row of the directed table: either a NAL beat or a register write
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  b;
    logic        first;
    logic [23:0] len;
    logic        au;
    logic [31:0] ts;
    logic [4:0]  n_out;   // output beats this row must cause
    logic [1:0]  ridx;
    logic [31:0] rval;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  nal_byte;
  logic        nal_first;
  logic [23:0] nal_length;
  logic        au_end;
  logic [31:0] stamp;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  pkt_byte;
  logic        pkt_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  rtp_h264_nal_packetizer dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .nal_byte   (nal_byte),
    .nal_first  (nal_first),
    .nal_length (nal_length),
    .au_end     (au_end),
    .stamp      (stamp),
    .empty      (empty),
    .pop        (pop),
    .pkt_byte   (pkt_byte),
    .pkt_last   (pkt_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Packetizer image: register copies and NAL / fragment state
  logic [31:0] cur_ssrc;
  logic [6:0]  cur_pt;
  logic [13:0] cur_max;
  logic [15:0] seq_num;
  logic        frag_on;
  logic [23:0] nal_left;
  logic [13:0] frag_fill;
  logic [7:0]  nal_hdr;
  logic        frag_start;
  logic [31:0] nal_stamp;
  logic        nal_mark;

  pkt_beat_t   pending_beats [$];   // packet bytes owed by the block, oldest first
  pkt_beat_t   want_beat;
  int unsigned n_in, n_out, n_err, n_pkts, n_frags;
  int          last_yield;          // beats caused by the most recent accepted NAL beat

  // Sender burst control and receiver stall pattern
  int unsigned burst_left;
  logic        steady;
  int          stall_count = 0;
  logic [15:0] stall_mask = 16'hffff;
  pop_mode_t   pop_mode;

  // Directed table: extremes, stray byte, zero length, early header, FU-A split
  dir_row_t dir_rows [28] = '{
    '{ROW_NAL, 8'hff, 1'b1, 24'd1,       1'b1, 32'hffff_ffff, 5'd13,    CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h00, 1'b0, 24'hff_ffff, 1'b1, 32'hffff_ffff, 5'd0,     CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h00, 1'b1, 24'd0,       1'b0, 32'h0,         5'd13,    CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h65, 1'b1, 24'd2,       1'b0, 32'h0102_0304, 5'd13,    CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'hab, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h41, 1'b1, 24'd3,       1'b1, 32'h89ab_cdef, 5'd13,    CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h06, 1'b1, 24'd1400,    1'b0, 32'h0000_ffff, 5'd13,    CFG_SSRC, 32'h0},
    '{ROW_REG, 8'h00, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'hffff_ffff},
    '{ROW_REG, 8'h00, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_PT,   32'hffff_ffff},
    '{ROW_REG, 8'h00, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_MAX,  32'hffff_c000},
    '{ROW_NAL, 8'hfc, 1'b1, 24'hff_ffff, 1'b1, 32'h0,         5'd0,     CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h11, 1'b0, 24'd0,       1'b0, 32'h0,         5'd15,    CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h65, 1'b1, 24'd17,      1'b1, 32'h8000_0000, 5'd0,     CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'hd0, 1'b0, 24'd0,       1'b0, 32'h0,         5'd15,    CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h01, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h02, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h04, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h08, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h10, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h20, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h40, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'h80, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'hfe, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'hfd, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'hfb, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'hf7, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'hef, 1'b0, 24'd0,       1'b0, 32'h0,         NO_CHECK, CFG_SSRC, 32'h0},
    '{ROW_NAL, 8'hee, 1'b0, 24'd0,       1'b0, 32'h0,         5'd15,    CFG_SSRC, 32'h0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t ns: timeout, %0d beats still owed", $time, pending_beats.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Payload size in force: anything under the floor acts as the floor
  function automatic logic [13:0] payload_limit();
    return (cur_max < MAX_FLOOR) ? MAX_FLOOR : cur_max;
  endfunction

  function automatic void owe_beat(input logic [7:0] d, input logic l);
    pending_beats.push_back('{data: d, last: l});
    last_yield++;
  endfunction

  // Queue the 12-byte RTP header and advance the sequence number
  function automatic void owe_rtp_header(input logic mark);
    owe_beat(RTP_VER_BYTE, 1'b0);
    owe_beat({mark, cur_pt}, 1'b0);
    owe_beat(seq_num[15:8], 1'b0);
    owe_beat(seq_num[7:0], 1'b0);
    owe_beat(nal_stamp[31:24], 1'b0);
    owe_beat(nal_stamp[23:16], 1'b0);
    owe_beat(nal_stamp[15:8], 1'b0);
    owe_beat(nal_stamp[7:0], 1'b0);
    owe_beat(cur_ssrc[31:24], 1'b0);
    owe_beat(cur_ssrc[23:16], 1'b0);
    owe_beat(cur_ssrc[15:8], 1'b0);
    owe_beat(cur_ssrc[7:0], 1'b0);
    seq_num = seq_num + 16'd1;
    n_pkts++;
  endfunction

  // Work out the packet bytes that one accepted NAL beat causes
  function automatic void packetize_beat(input logic [7:0] b, input logic first,
                                         input logic [23:0] len, input logic au,
                                         input logic [31:0] ts);
    logic [23:0] n_len;
    logic [13:0] room;
    logic        fin;
    logic        lst;
    last_yield = 0;
    if (first) begin
      // A header byte always opens a new NAL, abandoning any open one
      n_len      = (len == 24'd0) ? 24'd1 : len;
      nal_hdr    = b;
      nal_stamp  = ts;
      nal_mark   = au;
      frag_fill  = 14'd0;
      frag_start = 1'b1;
      nal_left   = n_len - 24'd1;
      if (n_len <= payload_limit()) begin
        frag_on = 1'b0;
        owe_rtp_header(au);
        owe_beat(b, nal_left == 24'd0);
      end else begin
        // Fragmented: the header byte only feeds the FU indicator and FU header
        frag_on = 1'b1;
      end
    end else if (nal_left != 24'd0) begin
      if (!frag_on) begin
        nal_left = nal_left - 24'd1;
        owe_beat(b, nal_left == 24'd0);
      end else begin
        room = payload_limit() - 14'd2;
        if (frag_fill == 14'd0) begin
          fin = (nal_left <= room);
          owe_rtp_header(nal_mark & fin);
          owe_beat(FU_A_TYPE | (nal_hdr & NRI_MASK), 1'b0);
          owe_beat({frag_start, fin, 1'b0, nal_hdr[4:0]}, 1'b0);
          n_frags++;
        end
        frag_fill = frag_fill + 14'd1;
        nal_left  = nal_left - 24'd1;
        lst = (nal_left == 24'd0) || (frag_fill >= room);
        owe_beat(b, lst);
        if (lst) begin
          frag_fill  = 14'd0;
          frag_start = 1'b0;
        end
        if (nal_left == 24'd0) frag_on = 1'b0;
      end
    end
  endfunction

  // Rising edge: check the output beat against the oldest expectation, then
  // fold an accepted input beat into the image. No output beat comes from the
  // input beat accepted at the same edge, so the order of the two steps does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_beats.size() == 0) begin
          $display("%0t ns: unexpected beat, expected none, got byte %02h last %0b",
                   $time, pkt_byte, pkt_last);
          n_err++;
        end else begin
          want_beat = pending_beats.pop_front();
          if (pkt_byte !== want_beat.data) begin
            $display("%0t ns: pkt_byte expected %02h, got %02h",
                     $time, want_beat.data, pkt_byte);
            n_err++;
          end
          if (pkt_last !== want_beat.last) begin
            $display("%0t ns: pkt_last expected %0b, got %0b",
                     $time, want_beat.last, pkt_last);
            n_err++;
          end
          n_out++;
        end
      end
      if (push && !full) begin
        packetize_beat(nal_byte, nal_first, nal_length, au_end, stamp);
        n_in++;
      end
    end
  end

  // Receiver: pick a new stall pattern whenever the last one runs out, including
  // stretches of steady popping and stretches of heavy back-pressure
  always @(negedge clk) begin
    if (stall_count == 0) begin
      stall_count = 48;
      pop_mode = pop_mode_t'($urandom_range(0, 3));
      case (pop_mode)
        POP_ALWAYS: stall_mask = 16'hffff;
        POP_RANDOM: stall_mask = 16'($urandom);
        POP_SPARSE: stall_mask = 16'h0001 << $urandom_range(0, 15);
        default:    stall_mask = 16'hff00 >> $urandom_range(0, 8);
      endcase
    end
    stall_count--;
    pop = stall_mask[stall_count[3:0]] && !rst;
  end

  // Drive one NAL beat at the falling edge and hold it until the block takes it;
  // bursts of random length are broken by random gaps unless the phase is steady
  task automatic send_nal_byte(input logic [7:0] b, input logic first,
                               input logic [23:0] len, input logic au,
                               input logic [31:0] ts);
    int unsigned taken;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    taken      = n_in;
    push       = 1'b1;
    nal_byte   = b;
    nal_first  = first;
    nal_length = len;
    au_end     = au;
    stamp      = ts;
    do @(negedge clk); while (n_in == taken);
  endtask

  // Hold input low until every owed beat has come out, then let the pipe settle
  task automatic wait_idle();
    push       = 1'b0;
    burst_left = 0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_SSRC: cur_ssrc = val;
      CFG_PT:   cur_pt   = val[6:0];
      CFG_MAX:  cur_max  = val[13:0];
      default:  ;
    endcase
  endtask

  // One random phase: set the registers, then stream mostly well-formed NALs
  // with random content, mixed with truncated NALs and stray bytes
  task automatic run_phase(input int unsigned quota, input logic [31:0] ssrc_val,
                           input logic [31:0] pt_val, input logic [31:0] max_val);
    int unsigned sent;
    int unsigned lim;
    int unsigned len;
    int unsigned nbytes;
    int unsigned k;
    logic [23:0] len_field;
    sent = 0;
    write_reg(CFG_SSRC, ssrc_val);
    write_reg(CFG_PT, pt_val);
    write_reg(CFG_MAX, max_val);
    lim    = (max_val[13:0] < MAX_FLOOR) ? MAX_FLOOR : max_val[13:0];
    steady = ($urandom_range(0, 3) == 0);
    while (sent < quota) begin
      // Favor the single/fragment boundary; keep NALs short for large limits
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = lim;
        2:       len = lim + 1;
        3:       len = 0;
        default: len = $urandom_range(2, 48);
      endcase
      if (len > 64) len = $urandom_range(1, 48);
      len_field = 24'(len);
      nbytes    = (len == 0) ? 1 : len;
      if ($urandom_range(0, 7) == 0) begin
        // Broken NAL: claim any length, stop after a few bytes
        len_field = 24'($urandom);
        nbytes    = $urandom_range(1, 6);
      end
      send_nal_byte(8'($urandom), 1'b1, len_field, 1'($urandom), $urandom);
      sent++;
      for (k = 1; k < nbytes; k++) begin
        send_nal_byte(8'($urandom), 1'b0, 24'($urandom), 1'($urandom), $urandom);
        sent++;
      end
      // Byte without nal_first: it extends a broken NAL that is still open, else it is ignored; not counted
      if ($urandom_range(0, 9) == 0)
        send_nal_byte(8'($urandom), 1'b0, 24'($urandom), 1'($urandom), $urandom);
    end
  endtask

  initial begin
    rst        = 1'b1;
    push       = 1'b0;
    nal_byte   = 8'h00;
    nal_first  = 1'b0;
    nal_length = 24'd0;
    au_end     = 1'b0;
    stamp      = 32'h0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_SSRC;
    cfg_data   = 32'h0;
    cur_ssrc   = SSRC_RESET;
    cur_pt     = PT_RESET;
    cur_max    = MAX_RESET;
    seq_num    = 16'd0;
    frag_on    = 1'b0;
    nal_left   = 24'd0;
    frag_fill  = 14'd0;
    nal_hdr    = 8'h00;
    frag_start = 1'b1;
    nal_stamp  = 32'h0;
    nal_mark   = 1'b0;
    n_in       = 0;
    n_out      = 0;
    n_err      = 0;
    n_pkts     = 0;
    n_frags    = 0;
    last_yield = 0;
    burst_left = 0;
    steady     = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table; counts typed in the table are cross-checked against the image
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        write_reg(dir_rows[i].ridx, dir_rows[i].rval);
      end else begin
        send_nal_byte(dir_rows[i].b, dir_rows[i].first, dir_rows[i].len,
                      dir_rows[i].au, dir_rows[i].ts);
        if (dir_rows[i].n_out != NO_CHECK && last_yield != int'(dir_rows[i].n_out)) begin
          $display("%0t ns: row %0d beat count expected %0d, got %0d",
                   $time, i, dir_rows[i].n_out, last_yield);
          n_err++;
        end
      end
    end

    // Random phases across register extremes and the sub-floor range
    run_phase(PHASE_BEATS, 32'h0, 32'h0, 32'd16);
    run_phase(PHASE_BEATS, 32'hffff_ffff, 32'h7f, 32'd9000);
    write_reg(CFG_NONE, $urandom);
    run_phase(PHASE_BEATS, $urandom, $urandom,
              $urandom_range(17, 40) | ($urandom & 32'hffff_c000));
    run_phase(PHASE_BEATS, $urandom, $urandom, $urandom_range(0, 15));
    run_phase(PHASE_BEATS, $urandom, $urandom, 32'd16383);
    run_phase(PHASE_BEATS, $urandom, $urandom, $urandom_range(17, 64));

    // Drain; the timeout covers a block that never delivers
    wait_idle();

    $display("Covered %0d NAL beats in and %0d packet beats out, %0d RTP packets",
             n_in, n_out, n_pkts);
    $display("of which %0d FU-A fragments, over seven register settings", n_frags);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rtp_pkg.sv
rtl/rtp_front.sv
rtl/rtp_cmdq.sv
rtl/rtp_back.sv
rtl/rtp_h264_nal_packetizer.sv
rtl/rtp_chk.sv
sim/tb_rtp_h264_nal_packetizer.sv
